FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/rjp_pkg.sv
// Shared types and constants for the RTP/JPEG packetizer.
// No dependencies; used by every module of the block.
package rjp_pkg;

   localparam int MAX_PAYLOAD_DEF = 1380;
   localparam int QUEUE_DEPTH     = 4;
   localparam int HDR_LEN         = 24;
   localparam int HDR_CNT_W       = $clog2(HDR_LEN + 1);

   // Register indexes on the configuration port
   localparam logic [2:0] REG_SSRC   = 3'd0;
   localparam logic [2:0] REG_WIDTH  = 3'd1;
   localparam logic [2:0] REG_HEIGHT = 3'd2;
   localparam logic [2:0] REG_TSTEP  = 3'd3;
   localparam logic [2:0] REG_PLIMIT = 3'd4;
   localparam logic [2:0] REG_CHAN   = 3'd5;

   // Register reset values
   localparam logic [31:0] SSRC_RST   = 32'd0;
   localparam logic [7:0]  WIDTH_RST  = 8'd80;
   localparam logic [7:0]  HEIGHT_RST = 8'd60;
   localparam logic [16:0] TSTEP_RST  = 17'd6000;
   localparam logic [10:0] PLIMIT_RST = 11'd1380;
   localparam logic [7:0]  CHAN_RST   = 8'd0;

   // Header byte constants
   localparam logic [7:0]  DOLLAR_BYTE = 8'h24;
   localparam logic [7:0]  RTP_VER     = 8'h80;
   localparam logic [7:0]  RTP_PT      = 8'd96;
   localparam logic [7:0]  MARKER_BIT  = 8'h80;
   localparam logic [7:0]  JPEG_Q      = 8'd255;
   localparam logic [15:0] PLEN_BASE   = 16'd20;

   typedef struct packed {
      logic [31:0] ssrc;
      logic [7:0]  wblk;
      logic [7:0]  hblk;
      logic [16:0] tstep;
      logic [10:0] plimit;
      logic [7:0]  chan;
   } cfg_type;

   // One queued data byte with the header snapshot of the packet it opens
   typedef struct packed {
      logic [7:0]  data;
      logic        has_hdr;
      logic        pend;
      logic        fend;
      logic        marker;
      logic [7:0]  chan;
      logic [15:0] plen;
      logic [15:0] seq;
      logic [31:0] ts;
      logic [31:0] ssrc;
      logic [23:0] offset;
      logic [7:0]  wblk;
      logic [7:0]  hblk;
   } entry_type;

endpackage

FILE: sv/rjp_front.sv
// Front end: accepts input transactions, tracks packet and frame state.
// Emits one queue entry per data byte; depends on rjp_pkg.
module rjp_front #(
   parameter int MAX_PAYLOAD = rjp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic               in_action,
   input  logic [7:0]         in_byte,
   input  logic [23:0]        in_flen,
   input  rjp_pkg::cfg_type   cfg,
   output logic               push,
   output rjp_pkg::entry_type push_entry,
   input  logic               q_full
);

   logic [15:0] seq_ff, seq_in;
   logic [31:0] ts_ff, ts_in;
   logic [23:0] off_ff, off_in;
   logic [10:0] cr_ff, cr_in;
   logic        marker_ff, marker_in;

   logic        accept;
   logic [10:0] limit;
   logic [23:0] remaining;
   logic        open_pkt;
   logic        marker;
   logic [10:0] chunk;
   logic [10:0] cr_dec;
   logic        pend;
   logic        fend;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign push     = accept && !in_action;

   always_comb begin
      limit = cfg.plimit;
      if (limit == 11'd0) begin
         limit = 11'd1;
      end else if (limit > 11'(MAX_PAYLOAD)) begin
         limit = 11'(MAX_PAYLOAD);
      end
      remaining = (off_ff < in_flen) ? (in_flen - off_ff) : 24'd1;
      open_pkt  = (cr_ff == 11'd0);
      if (open_pkt) begin
         marker = (remaining <= {13'd0, limit});
         chunk  = marker ? remaining[10:0] : limit;
      end else begin
         marker = marker_ff;
         chunk  = cr_ff;
      end
      cr_dec = chunk - 11'd1;
      pend   = (cr_dec == 11'd0);
      fend   = pend && marker;

      push_entry.data    = in_byte;
      push_entry.has_hdr = open_pkt;
      push_entry.pend    = pend;
      push_entry.fend    = fend;
      push_entry.marker  = marker;
      push_entry.chan    = cfg.chan;
      push_entry.plen    = rjp_pkg::PLEN_BASE + {5'd0, chunk};
      push_entry.seq     = seq_ff;
      push_entry.ts      = ts_ff;
      push_entry.ssrc    = cfg.ssrc;
      push_entry.offset  = off_ff;
      push_entry.wblk    = cfg.wblk;
      push_entry.hblk    = cfg.hblk;

      seq_in    = seq_ff;
      ts_in     = ts_ff;
      off_in    = off_ff;
      cr_in     = cr_ff;
      marker_in = marker_ff;
      if (accept) begin
         if (in_action) begin
            seq_in    = '0;
            ts_in     = '0;
            off_in    = '0;
            cr_in     = '0;
            marker_in = 1'b0;
         end else begin
            cr_in     = cr_dec;
            off_in    = fend ? 24'd0 : off_ff + 24'd1;
            seq_in    = pend ? seq_ff + 16'd1 : seq_ff;
            ts_in     = fend ? ts_ff + {15'd0, cfg.tstep} : ts_ff;
            marker_in = pend ? 1'b0 : marker;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= '0;
         ts_ff     <= '0;
         off_ff    <= '0;
         cr_ff     <= '0;
         marker_ff <= 1'b0;
      end else begin
         seq_ff    <= seq_in;
         ts_ff     <= ts_in;
         off_ff    <= off_in;
         cr_ff     <= cr_in;
         marker_ff <= marker_in;
      end
   end

endmodule

FILE: sv/rjp_queue.sv
// Short FIFO of data-byte entries between front and back ends.
// Depends on rjp_pkg for the entry type and depth.
module rjp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rjp_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output rjp_pkg::entry_type head_entry
);

   localparam int DEPTH = rjp_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rjp_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? PTR_W'((32'(wr_ff) + 1) % DEPTH) : wr_ff;
      rd_in  = do_pop ? PTR_W'((32'(rd_ff) + 1) % DEPTH) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

FILE: sv/rjp_back.sv
// Back end: serializes the 24-byte prefix of each entry that opens a packet and the data byte of every entry.
// Holds the output register; depends on rjp_pkg.
module rjp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  rjp_pkg::entry_type head_entry,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_byte,
   output logic               out_pend,
   output logic               out_fend,
   output logic               out_lor,
   output logic [rjp_pkg::HDR_CNT_W-1:0] hdr_cnt
);

   localparam int CW = rjp_pkg::HDR_CNT_W;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          valid_ff, valid_in;
   logic [7:0]    byte_ff, byte_in;
   logic          pend_ff, pend_in;
   logic          fend_ff, fend_in;
   logic          lor_ff, lor_in;
   logic          load;
   logic          in_hdr;
   logic [7:0]    hdr_byte;

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_pend  = pend_ff;
   assign out_fend  = fend_ff;
   assign out_lor   = lor_ff;
   assign hdr_cnt   = cnt_ff;

   assign load   = !valid_ff || out_ready;
   assign in_hdr = head_entry.has_hdr && (cnt_ff != CW'(rjp_pkg::HDR_LEN));

   always_comb begin
      case (cnt_ff)
         CW'(0):  hdr_byte = rjp_pkg::DOLLAR_BYTE;
         CW'(1):  hdr_byte = head_entry.chan;
         CW'(2):  hdr_byte = head_entry.plen[15:8];
         CW'(3):  hdr_byte = head_entry.plen[7:0];
         CW'(4):  hdr_byte = rjp_pkg::RTP_VER;
         CW'(5):  hdr_byte = head_entry.marker ? (rjp_pkg::MARKER_BIT | rjp_pkg::RTP_PT)
                                               : rjp_pkg::RTP_PT;
         CW'(6):  hdr_byte = head_entry.seq[15:8];
         CW'(7):  hdr_byte = head_entry.seq[7:0];
         CW'(8):  hdr_byte = head_entry.ts[31:24];
         CW'(9):  hdr_byte = head_entry.ts[23:16];
         CW'(10): hdr_byte = head_entry.ts[15:8];
         CW'(11): hdr_byte = head_entry.ts[7:0];
         CW'(12): hdr_byte = head_entry.ssrc[31:24];
         CW'(13): hdr_byte = head_entry.ssrc[23:16];
         CW'(14): hdr_byte = head_entry.ssrc[15:8];
         CW'(15): hdr_byte = head_entry.ssrc[7:0];
         CW'(16): hdr_byte = 8'd0;
         CW'(17): hdr_byte = head_entry.offset[23:16];
         CW'(18): hdr_byte = head_entry.offset[15:8];
         CW'(19): hdr_byte = head_entry.offset[7:0];
         CW'(20): hdr_byte = 8'd0;
         CW'(21): hdr_byte = rjp_pkg::JPEG_Q;
         CW'(22): hdr_byte = head_entry.wblk;
         CW'(23): hdr_byte = head_entry.hblk;
         default: hdr_byte = 8'd0;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      pend_in  = pend_ff;
      fend_in  = fend_ff;
      lor_in   = lor_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (in_hdr) begin
               byte_in = hdr_byte;
               pend_in = 1'b0;
               fend_in = 1'b0;
               lor_in  = 1'b0;
               cnt_in  = cnt_ff + CW'(1);
            end else begin
               // data byte closes the entry: pop and rewind the prefix counter
               byte_in = head_entry.data;
               pend_in = head_entry.pend;
               fend_in = head_entry.fend;
               lor_in  = 1'b1;
               cnt_in  = '0;
               pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      pend_ff <= pend_in;
      fend_ff <= fend_in;
      lor_ff  <= lor_in;
   end

endmodule

FILE: sv/rtp_jpeg_packetizer.sv
// Top level of the RTP/JPEG packetizer: config registers, front, queue, back.
// Depends on rjp_pkg, rjp_front, rjp_queue, rjp_back and assert_macros.svh.
//
//   channel | direction | tdata / data               | tuser                  | tlast
//   req_    | in        | [7:0] jpeg_byte,           | [0] action             | -
//           |           | [31:8] frame_length        |                        |
//   rsp_    | out       | [7:0] out_byte             | [0] frame_end,         | packet_end
//           |           |                            | [1] last_of_run        |
//   csr_    | in        | csr_index [2:0], csr_data [31:0] write                          |
//
// One input byte per cycle while the queue is not full; a byte that opens a packet
// occupies the output for its 24 prefix bytes plus the data byte, serialized through the
// single output register of the back end. A four-entry queue lets the front keep accepting meanwhile.
// Reset is synchronous and clears control state and registers at once.
// Restart transactions produce no output.
`include "assert_macros.svh"

module rtp_jpeg_packetizer #(
   parameter int MAX_PAYLOAD = rjp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [7:0] jpeg_byte, [31:8] frame_length
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [0] frame_end, [1] last_of_run
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   rjp_pkg::cfg_type   cfg_ff, cfg_in;
   rjp_pkg::entry_type push_entry;
   rjp_pkg::entry_type head_entry;
   logic               push;
   logic               q_full;
   logic               pop;
   logic               head_valid;
   logic               out_fend;
   logic               out_lor;
   logic [rjp_pkg::HDR_CNT_W-1:0] hdr_cnt;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rjp_pkg::REG_SSRC:   cfg_in.ssrc   = csr_data;
            rjp_pkg::REG_WIDTH:  cfg_in.wblk   = csr_data[7:0];
            rjp_pkg::REG_HEIGHT: cfg_in.hblk   = csr_data[7:0];
            rjp_pkg::REG_TSTEP:  cfg_in.tstep  = csr_data[16:0];
            rjp_pkg::REG_PLIMIT: cfg_in.plimit = csr_data[10:0];
            rjp_pkg::REG_CHAN:   cfg_in.chan   = csr_data[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ssrc   <= rjp_pkg::SSRC_RST;
         cfg_ff.wblk   <= rjp_pkg::WIDTH_RST;
         cfg_ff.hblk   <= rjp_pkg::HEIGHT_RST;
         cfg_ff.tstep  <= rjp_pkg::TSTEP_RST;
         cfg_ff.plimit <= rjp_pkg::PLIMIT_RST;
         cfg_ff.chan   <= rjp_pkg::CHAN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rjp_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_action  (req_tuser),
      .in_byte    (req_tdata[7:0]),
      .in_flen    (req_tdata[31:8]),
      .cfg        (cfg_ff),
      .push       (push),
      .push_entry (push_entry),
      .q_full     (q_full)
   );

   rjp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   rjp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_pend   (rsp_tlast),
      .out_fend   (out_fend),
      .out_lor    (out_lor),
      .hdr_cnt    (hdr_cnt)
   );

   assign rsp_tuser = {out_lor, out_fend};

   // frame end only on a packet's closing byte
   `ASSERT_IMPLIES(a_fend_on_pend, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast)
   // a packet's closing byte is always a data byte
   `ASSERT_IMPLIES(a_pend_is_data, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser[1])
   // prefix counter stays within the header
   `ASSERT_IMPLIES(a_hdr_cnt_range, clock, reset, 1'b1, hdr_cnt <= rjp_pkg::HDR_CNT_W'(rjp_pkg::HDR_LEN))
   // a restart never adds a queue entry
   `ASSERT_IMPLIES(a_restart_no_push, clock, reset, req_tvalid && req_tready && req_tuser, !push)

endmodule
